>>> rtl/dpi_pkg.sv
package dpi_pkg;

    localparam int DATA_W  = 32;
    localparam int LAYER_W = 6;
    localparam int FUNC_W  = 2;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // Function codes of an input item.
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] entry_depth;
        logic signed [DATA_W-1:0] entry_north;
        logic signed [DATA_W-1:0] entry_east;
        logic signed [DATA_W-1:0] vehicle_depth;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] north_velocity;
        logic signed [DATA_W-1:0] east_velocity;
        logic [LAYER_W-1:0]       layer_used;
        logic                     result_valid;
        logic                     table_full;
    } t_out_item;

    // One stored layer of the profile.
    typedef struct packed {
        logic signed [DATA_W-1:0] depth;
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] east;
    } t_layer;

endpackage

>>> rtl/dpi_stream_if.sv
interface dpi_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/depth_profile_interpolator.sv
// Clear and append are handled on acceptance; an append result is in the output register next cycle.
// A query result goes through the depth scan, which reads one layer per cycle, and then each velocity
// goes in turn through the shared multiply and divide unit.
// Throughput: one item at a time; the input is not ready while a query is being worked on.
// Reset (synchronous, active low) empties the table, forgets the remembered layer and drops any
// pending result; the table contents themselves are not cleared.
module depth_profile_interpolator #(
    parameter int TABLE_DEPTH    = 64,
    parameter int MAX_INDEX_JUMP = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dpi_stream_if.sink    i_req,
    dpi_stream_if.source  o_rsp
);
    import dpi_pkg::*;

    // Index width addresses the table; count width can also hold the full depth.
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states. SCAN walks the table, GUARD applies the jump limit, RLO/RHI/CAPT
    // fetch the bracketing layers, and PREP..FIN run one velocity through the shared unit.
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SCAN  = 12'b0000_0000_0010,
        S_GUARD = 12'b0000_0000_0100,
        S_RLO   = 12'b0000_0000_1000,
        S_RHI   = 12'b0000_0001_0000,
        S_CAPT  = 12'b0000_0010_0000,
        S_PREP  = 12'b0000_0100_0000,
        S_MUL   = 12'b0000_1000_0000,
        S_DSET  = 12'b0001_0000_0000,
        S_DIV   = 12'b0010_0000_0000,
        S_FIN   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Control state.
    logic [CW-1:0]        r_layer_cnt;
    logic [IW-1:0]        r_last;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_chk_vld;
    logic                 r_lane;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Datapath registers.
    t_layer                   r_mem [TABLE_DEPTH];
    t_layer                   r_rd_data;
    t_layer                   r_lo;
    t_layer                   r_hi;
    t_out_item                r_out;
    logic signed [DATA_W-1:0] r_vd;
    logic [CW-1:0]            r_scan;
    logic [IW-1:0]            r_chk_idx;
    logic [IW-1:0]            r_idx;
    logic [IW-1:0]            r_addr;
    logic [DATA_W-1:0]        r_span_mag;
    logic                     r_span_neg;
    logic [DATA_W-1:0]        r_dv_mag;
    logic                     r_dv_neg;
    logic [DATA_W-1:0]        r_ma;
    logic                     r_neg;
    logic [2*DATA_W-1:0]      r_prod;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_quo;
    logic                     r_sat;
    logic signed [DATA_W-1:0] r_res_n;
    logic signed [DATA_W-1:0] r_res_e;

    // Absolute value of a 33-bit difference of two 32-bit values; it always fits in 32 bits.
    function automatic logic [DATA_W-1:0] mag33(input logic [DATA_W:0] v);
        logic [DATA_W:0] t;
        t = v[DATA_W] ? (~v + 1'b1) : v;
        return t[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Handshakes. A new item is taken only when the sequencer is idle and the output
    // register will be free at this edge, so an append result can be loaded at once.
    // ------------------------------------------------------------------
    logic slot_free;
    logic in_acc;

    assign slot_free     = !r_out_valid || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE) && slot_free;
    assign in_acc        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // The output register is loaded by an append, by a query on an empty table and by a
    // finished query; otherwise it empties once its item has been taken.
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        if ((r_state == S_IDLE) && in_acc) begin
            if ((i_req.payload.func == FUNC_APPEND)
                || ((i_req.payload.func == FUNC_QUERY) && (r_layer_cnt == '0))) begin
                n_out_valid = 1'b1;
            end
        end
        if ((r_state == S_DONE) && slot_free) begin
            n_out_valid = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers for the current state.
    // ------------------------------------------------------------------
    logic [CW-1:0]             cnt_m1;
    logic                      can_append;
    logic                      scan_hit;
    logic                      scan_last;
    logic [IW-1:0]             li;
    logic [IW-1:0]             diff;
    logic [IW-1:0]             idx_g;
    logic signed [DATA_W:0]    span_w;
    logic signed [DATA_W:0]    dv_w;
    logic signed [DATA_W-1:0]  vlo;
    logic signed [DATA_W-1:0]  vhi;
    logic signed [DATA_W:0]    dn_w;
    logic [DATA_W:0]           trial;
    logic                      trial_ge;
    logic signed [DATA_W+1:0]  sum_w;
    logic signed [DATA_W-1:0]  fin_val;
    logic [IW-1:0]             rd_addr;

    assign cnt_m1     = r_layer_cnt - 1'b1;
    assign can_append = r_layer_cnt < CW'(TABLE_DEPTH);

    // The first layer after layer 0 that lies strictly deeper than the vehicle ends the scan;
    // running past the last stored layer means no bracket was found.
    assign scan_hit  = r_rd_data.depth > r_vd;
    assign scan_last = CW'(r_chk_idx) == cnt_m1;

    // Jump guard: a remembered index at or beyond the count is stale and counts as unset.
    always_comb begin
        li    = (CW'(r_last) < r_layer_cnt) ? r_last : '0;
        diff  = (r_idx > li) ? (r_idx - li) : (li - r_idx);
        idx_g = r_idx;
        if ((li != '0) && (32'(diff) > 32'(MAX_INDEX_JUMP))) begin
            idx_g = li;
        end
    end

    // Spans measured from the lower layer; r_rd_data holds the upper layer in CAPT.
    assign span_w = {r_rd_data.depth[DATA_W-1], r_rd_data.depth}
                  - {r_lo.depth[DATA_W-1], r_lo.depth};
    assign dv_w   = {r_vd[DATA_W-1], r_vd} - {r_lo.depth[DATA_W-1], r_lo.depth};

    // The shared unit works on the north lane first, then on the east lane.
    assign vlo  = r_lane ? r_lo.east : r_lo.north;
    assign vhi  = r_lane ? r_hi.east : r_hi.north;
    assign dn_w = {vhi[DATA_W-1], vhi} - {vlo[DATA_W-1], vlo};

    // Restoring division step: one quotient bit per cycle.
    assign trial    = {r_rem, r_quo[DATA_W-1]};
    assign trial_ge = trial >= {1'b0, r_span_mag};

    // Final add of the truncated quotient to the lower velocity, saturated to 32 bits. A
    // quotient of 2^32 or more always saturates, whatever the lower velocity is.
    always_comb begin
        sum_w = r_neg ? ({{2{vlo[DATA_W-1]}}, vlo} - {2'b00, r_quo})
                      : ({{2{vlo[DATA_W-1]}}, vlo} + {2'b00, r_quo});
        if (r_sat) begin
            fin_val = r_neg ? SAT_MIN : SAT_MAX;
        end else if ((sum_w[DATA_W+1:DATA_W-1] != 3'b000)
                     && (sum_w[DATA_W+1:DATA_W-1] != 3'b111)) begin
            fin_val = sum_w[DATA_W+1] ? SAT_MIN : SAT_MAX;
        end else begin
            fin_val = sum_w[DATA_W-1:0];
        end
    end

    // Table read address: the scan pointer while scanning, the upper layer in RHI,
    // otherwise the prepared lower address.
    always_comb begin
        case (r_state)
            S_SCAN:  rd_addr = r_scan[IW-1:0];
            S_RHI:   rd_addr = r_idx;
            default: rd_addr = r_addr;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req.payload.func == FUNC_QUERY) && (r_layer_cnt != '0)) begin
                    n_state = (r_layer_cnt == CW'(1)) ? S_GUARD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && (scan_hit || scan_last)) begin
                    n_state = S_GUARD;
                end
            end
            S_GUARD: n_state = S_RLO;
            S_RLO:   n_state = S_RHI;
            S_RHI:   n_state = S_CAPT;
            S_CAPT: begin
                n_state = ((r_idx == '0) || (span_w == '0)) ? S_DONE : S_PREP;
            end
            S_PREP:  n_state = S_MUL;
            S_MUL:   n_state = S_DSET;
            S_DSET: begin
                n_state = (r_prod[2*DATA_W-1:DATA_W] >= r_span_mag) ? S_FIN : S_DIV;
            end
            S_DIV: begin
                if (r_div_cnt == '1) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = r_lane ? S_DONE : S_PREP;
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Layer table: one write port for appends, one registered read port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req.payload.func == FUNC_APPEND) && can_append) begin
            r_mem[r_layer_cnt[IW-1:0]] <= '{depth: i_req.payload.entry_depth,
                                           north: i_req.payload.entry_north,
                                           east:  i_req.payload.entry_east};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Control and datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_layer_cnt <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_lane      <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_req.payload.func)
                            FUNC_CLEAR: begin
                                r_layer_cnt <= '0;
                            end
                            FUNC_APPEND: begin
                                // The result only says whether the layer was dropped.
                                r_out <= '{north_velocity: '0,
                                           east_velocity:  '0,
                                           layer_used:     '0,
                                           result_valid:   1'b0,
                                           table_full:     !can_append};
                                if (can_append) begin
                                    r_layer_cnt <= r_layer_cnt + 1'b1;
                                end
                            end
                            FUNC_QUERY: begin
                                r_vd      <= i_req.payload.vehicle_depth;
                                r_scan    <= CW'(1);
                                r_chk_vld <= 1'b0;
                                r_idx     <= '0;
                                r_lane    <= 1'b0;
                                // An empty table answers at once with every field zero.
                                if (r_layer_cnt == '0) begin
                                    r_out <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Reads are issued one per cycle; r_chk_idx names the layer whose depth
                    // is in r_rd_data this cycle.
                    if (r_chk_vld && scan_hit) begin
                        r_idx <= r_chk_idx;
                    end else if (r_chk_vld && scan_last) begin
                        r_idx <= '0;
                    end
                    if (r_scan < r_layer_cnt) begin
                        r_chk_idx <= r_scan[IW-1:0];
                        r_chk_vld <= 1'b1;
                        r_scan    <= r_scan + 1'b1;
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                end
                S_GUARD: begin
                    r_idx  <= idx_g;
                    r_last <= idx_g;
                    // With no bracket the last layer stands in as the lower layer.
                    r_addr <= (idx_g == '0) ? cnt_m1[IW-1:0] : (idx_g - 1'b1);
                end
                S_RHI: begin
                    r_lo <= r_rd_data;
                end
                S_CAPT: begin
                    r_hi       <= r_rd_data;
                    r_res_n    <= r_lo.north;
                    r_res_e    <= r_lo.east;
                    r_span_mag <= mag33(span_w);
                    r_span_neg <= span_w[DATA_W];
                    r_dv_mag   <= mag33(dv_w);
                    r_dv_neg   <= dv_w[DATA_W];
                end
                S_PREP: begin
                    r_ma  <= mag33(dn_w);
                    r_neg <= dn_w[DATA_W] ^ r_dv_neg ^ r_span_neg;
                end
                S_MUL: begin
                    r_prod <= r_ma * r_dv_mag;
                end
                S_DSET: begin
                    // A high half not below the divisor means a quotient of 2^32 or more.
                    r_sat     <= r_prod[2*DATA_W-1:DATA_W] >= r_span_mag;
                    r_rem     <= r_prod[2*DATA_W-1:DATA_W];
                    r_quo     <= r_prod[DATA_W-1:0];
                    r_div_cnt <= '0;
                end
                S_DIV: begin
                    r_rem     <= trial_ge ? DATA_W'(trial - {1'b0, r_span_mag})
                                          : trial[DATA_W-1:0];
                    r_quo     <= {r_quo[DATA_W-2:0], trial_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                end
                S_FIN: begin
                    if (r_lane) begin
                        r_res_e <= fin_val;
                    end else begin
                        r_res_n <= fin_val;
                    end
                    r_lane <= 1'b1;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_out.north_velocity <= r_res_n;
                        r_out.east_velocity  <= r_res_e;
                        r_out.layer_used     <= LAYER_W'(r_idx);
                        r_out.result_valid   <= 1'b1;
                        r_out.table_full     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checks on the sequencer and the shared divider.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_layer_cnt) <= 32'(TABLE_DEPTH))
        else $error("layer count beyond table depth");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_chk_vld |-> CW'(r_chk_idx) < r_layer_cnt)
        else $error("scan checks a layer beyond the count");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_rem < r_span_mag)
        else $error("division remainder not below divisor");

    a_div_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> r_div_cnt == '0)
        else $error("division counter running outside the divide loop");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && slot_free |=> r_out_valid && r_out.result_valid)
        else $error("finished query did not reach the output register");

endmodule
